### hdl/sarc_pkg.sv
// shared types and constants for the summed-area rectangle counter
// used by sarc_ctrl, sarc_dpath and summed_area_rectangle_count; no dependencies

package sarc_pkg;

    localparam int CNT_W      = 17;
    localparam int COORD_W    = 9;
    localparam int SIDE_W     = 9;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 9'd256;

    // register index, taken from paddr[2]
    localparam logic REG_SIDE = 1'b0;

    // item kinds carried in tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic take_load;   // load transaction accepted, read the entry above
        logic take_query;  // query transaction accepted, read first corner pair
        logic rd2;         // read second corner pair, keep first difference
        logic wr_cell;     // write the new table entry and advance position
        logic put_out;     // register the result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic loaded;
    } t_stat;

endpackage

### hdl/sarc_ctrl.sv
// controller state machine for the summed-area rectangle counter
// depends on sarc_pkg; drives the commands of sarc_dpath

module sarc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    input  logic            i_mode,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  sarc_pkg::t_stat i_stat,
    output sarc_pkg::t_cmd  o_cmd
);
    import sarc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_QRD2,
        S_QOUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_take;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign w_take     = i_s_tvalid && o_s_tready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_mode == MODE_QUERY) begin
                        o_cmd.take_query = 1'b1;
                        n_state          = S_QRD2;
                    end else if (!i_stat.loaded) begin
                        o_cmd.take_load = 1'b1;
                        n_state         = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.wr_cell = 1'b1;
                n_state       = S_IDLE;
            end
            S_QRD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_QOUT;
            end
            S_QOUT: begin
                // hold here while the previous result is still pending
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.put_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.put_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.put_out |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten while pending");

    a_write_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_load |=> o_cmd.wr_cell)
        else $error("table write did not follow load transaction");

    a_rd2_follows_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_query |=> o_cmd.rd2)
        else $error("second read did not follow query transaction");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.take_load, o_cmd.take_query, o_cmd.rd2,
                  o_cmd.wr_cell, o_cmd.put_out}))
        else $error("more than one command at once");

endmodule

### hdl/sarc_dpath.sv
// datapath for the summed-area rectangle counter: side register, load position,
// table memory with two registered read ports, rectangle arithmetic; uses sarc_pkg

module sarc_dpath #(
    parameter int MAX_SIDE = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr,
    input  logic [sarc_pkg::SIDE_W-1:0]          i_cfg_side,
    output logic [sarc_pkg::SIDE_W-1:0]          o_side,
    input  logic                                 i_cell_req,
    input  logic [sarc_pkg::COORD_W-1:0]         i_top_row,
    input  logic [sarc_pkg::COORD_W-1:0]         i_left_col,
    input  logic [sarc_pkg::COORD_W-1:0]         i_bottom_row,
    input  logic [sarc_pkg::COORD_W-1:0]         i_right_col,
    input  sarc_pkg::t_cmd                       i_cmd,
    output sarc_pkg::t_stat                      o_stat,
    output logic [sarc_pkg::CNT_W-1:0]           o_count,
    output logic                                 o_bad_query
);
    import sarc_pkg::*;

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = COORD_W + $clog2(MAX_SIDE) + 1;
    localparam logic [10:0] MAX_SIDE_W = 11'(MAX_SIDE);

    // entries are kept modulo 2^CNT_W; the four-term difference stays exact
    logic [CNT_W-1:0] mem [DEPTH];

    logic [SIDE_W-1:0]  r_side;
    logic [SIDE_W-1:0]  w_side_use;
    logic [COORD_W-1:0] r_load_row;
    logic [COORD_W-1:0] r_load_col;
    logic [COORD_W-1:0] r_row_sum;
    logic               r_loaded;
    logic [COORD_W-1:0] n_row_sum;
    logic [COORD_W-1:0] n_col;

    logic               r_cell;
    logic [COORD_W-1:0] r_top;
    logic [COORD_W-1:0] r_left;
    logic [COORD_W-1:0] r_bot;
    logic               r_top_one;
    logic               r_left_one;
    logic               r_bad;

    logic [AW-1:0]      w_rd_addr_a;
    logic [AW-1:0]      w_rd_addr_b;
    logic               w_rd_en;
    logic [CNT_W-1:0]   r_rd_a;
    logic [CNT_W-1:0]   r_rd_b;
    logic [AW-1:0]      w_wr_addr;
    logic [CNT_W-1:0]   w_entry;
    logic [CNT_W-1:0]   r_part;
    logic [CNT_W-1:0]   w_sum;
    logic               w_bad;
    logic [CNT_W-1:0]   r_out_count;
    logic               r_out_bad;

    function automatic logic [AW-1:0] f_addr(input logic [COORD_W-1:0] row,
                                             input logic [COORD_W-1:0] col);
        logic [PW-1:0] lin;
        begin
            lin = PW'(row) * PW'(MAX_SIDE) + PW'(col);
            return lin[AW-1:0];
        end
    endfunction

    always_comb begin
        if (r_side == '0) begin
            w_side_use = SIDE_W'(1);
        end else if ({2'b00, r_side} > MAX_SIDE_W) begin
            w_side_use = SIDE_W'(MAX_SIDE);
        end else begin
            w_side_use = r_side;
        end
    end

    assign o_side        = r_side;
    assign o_stat.loaded = r_loaded;

    // query rejection, from the transaction fields as they arrive
    assign w_bad = !r_loaded || (i_top_row == '0) || (i_left_col == '0)
                || (i_top_row > i_bottom_row) || (i_left_col > i_right_col)
                || (i_bottom_row > w_side_use) || (i_right_col > w_side_use);

    // read address select; corners at row or column zero read garbage that is masked
    always_comb begin
        w_rd_addr_a = f_addr(r_load_row - COORD_W'(1), r_load_col);
        w_rd_addr_b = w_rd_addr_a;
        if (i_cmd.take_query) begin
            w_rd_addr_a = f_addr(i_bottom_row - COORD_W'(1), i_right_col - COORD_W'(1));
            w_rd_addr_b = f_addr(i_top_row - COORD_W'(2), i_right_col - COORD_W'(1));
        end else if (i_cmd.rd2) begin
            w_rd_addr_a = f_addr(r_bot - COORD_W'(1), r_left - COORD_W'(2));
            w_rd_addr_b = f_addr(r_top - COORD_W'(2), r_left - COORD_W'(2));
        end
    end

    assign w_rd_en = i_cmd.take_load || i_cmd.take_query || i_cmd.rd2;

    assign n_row_sum = r_row_sum + COORD_W'(r_cell);
    assign n_col     = r_load_col + COORD_W'(1);
    assign w_wr_addr = f_addr(r_load_row, r_load_col);
    assign w_entry   = CNT_W'(n_row_sum) + ((r_load_row == '0) ? '0 : r_rd_a);

    assign w_sum = r_part - (r_left_one ? '0 : r_rd_a)
                 + ((r_top_one || r_left_one) ? '0 : r_rd_b);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_cell) begin
            mem[w_wr_addr] <= w_entry;
        end
        if (w_rd_en) begin
            r_rd_a <= mem[w_rd_addr_a];
            r_rd_b <= mem[w_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side     <= SIDE_RESET;
            r_load_row <= '0;
            r_load_col <= '0;
            r_row_sum  <= '0;
            r_loaded   <= 1'b0;
        end else if (i_cfg_wr) begin
            r_side     <= i_cfg_side;
            r_load_row <= '0;
            r_load_col <= '0;
            r_row_sum  <= '0;
            r_loaded   <= 1'b0;
        end else if (i_cmd.wr_cell) begin
            if (n_col >= w_side_use) begin
                r_load_col <= '0;
                r_row_sum  <= '0;
                r_load_row <= r_load_row + COORD_W'(1);
                if (r_load_row + COORD_W'(1) >= w_side_use) begin
                    r_loaded <= 1'b1;
                end
            end else begin
                r_load_col <= n_col;
                r_row_sum  <= n_row_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_load) begin
            r_cell <= i_cell_req;
        end
        if (i_cmd.take_query) begin
            r_top      <= i_top_row;
            r_left     <= i_left_col;
            r_bot      <= i_bottom_row;
            r_top_one  <= (i_top_row == COORD_W'(1));
            r_left_one <= (i_left_col == COORD_W'(1));
            r_bad      <= w_bad;
        end
        if (i_cmd.rd2) begin
            r_part <= r_rd_a - (r_top_one ? '0 : r_rd_b);
        end
        if (i_cmd.put_out) begin
            r_out_count <= r_bad ? '0 : w_sum;
            r_out_bad   <= r_bad;
        end
    end

    assign o_count     = r_out_count;
    assign o_bad_query = r_out_bad;

endmodule

### hdl/summed_area_rectangle_count.sv
// Summed-area table over a square binary grid with rectangle-count queries.
// Load items (tuser = 0) stream the cells in raster order; each builds one table
// entry from the running row sum and the entry above. Query items (tuser = 1)
// return the marked-cell count of an inclusive 1-based rectangle, or bad_query
// with a zero count for reversed or out-of-range corners or an unfinished grid.
// A load reads the entry above, then writes the new entry; a query reads two
// corner pairs on the dual-read table, then forms the sum, and waits while the
// previous result has not been taken. The steps follow from the table memory's
// registered read. Writing the side register restarts loading.
// Depends on sarc_pkg, sarc_ctrl and sarc_dpath.

module summed_area_rectangle_count #(
    parameter int MAX_SIDE = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // apb configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sarc_pkg::APB_AW-1:0]          paddr,
    input  logic [sarc_pkg::APB_DW-1:0]          pwdata,
    output logic [sarc_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [0] cell_req, [9:1] top_row, [18:10] left_col, [27:19] bottom_row,
    // [36:28] right_col, [39:37] zero
    input  logic [sarc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] mode
    input  logic                                 s_axis_tuser,
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [16:0] count, [23:17] zero
    output logic [sarc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] bad_query
    output logic                                 m_axis_tuser
);
    import sarc_pkg::*;

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic              w_cfg_wr;
    logic [SIDE_W-1:0] w_side;
    logic [CNT_W-1:0]  w_count;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIDE);
    assign prdata   = (paddr[2] == REG_SIDE) ? APB_DW'(w_side) : '0;

    sarc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_mode     (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sarc_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (w_cfg_wr),
        .i_cfg_side   (pwdata[SIDE_W-1:0]),
        .o_side       (w_side),
        .i_cell_req   (s_axis_tdata[0]),
        .i_top_row    (s_axis_tdata[9:1]),
        .i_left_col   (s_axis_tdata[18:10]),
        .i_bottom_row (s_axis_tdata[27:19]),
        .i_right_col  (s_axis_tdata[36:28]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_count      (w_count),
        .o_bad_query  (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TDATA_W'(w_count);

endmodule
